// ===== hw/rtl/skts_pkg.sv =====
// ---------------------------------------------------------------------------
// skts_pkg
// shared types and constants for the sorted key table search block
// ---------------------------------------------------------------------------
package skts_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int KEY_W           = 64;
  localparam int VALUE_W         = 32;
  localparam int POS_W           = 12;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } skts_op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [KEY_W-1:0]   search_key;
    logic [VALUE_W-1:0] entry_value;
  } skts_in_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] found_value;
    logic [POS_W-1:0]   found_position;
  } skts_out_t;

endpackage

// ===== hw/rtl/skts_ram.sv =====
// ---------------------------------------------------------------------------
// skts_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module skts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_key_table_search.sv =====
// ---------------------------------------------------------------------------
// sorted_key_table_search
// table of text keys with value offsets, searched by binary search
// ---------------------------------------------------------------------------
// usage
// - an input transfer happens at a clock edge with start high and busy low;
//   in_data carries the operation, the key and the value offset
// - clear and append finish in the transfer cycle itself: busy stays low and
//   another command may follow in the very next cycle; neither gives a result
// - a lookup raises busy and walks the table with a binary search over the
//   key ram, whose read data is registered; the next read address is chosen
//   in the same cycle the probed key returns
// - a lookup makes at most floor(log2(entry_count)) + 1 probes; an empty
//   table answers without raising busy
// - the result shows on out_data for one cycle with out_valid high; the
//   receiver cannot stall it, and busy is already low in that cycle
// - reset empties the table (entry count to zero); ram contents are left
//   as they are and are never read before being written
// - keys are normalized: only the top KEY_BYTES bytes count and all bytes
//   after the first zero byte read as zero
// ---------------------------------------------------------------------------
module sorted_key_table_search
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  skts_in_t  in_data,
  output logic      out_valid,
  output skts_out_t out_data
);

  // address width of the rams and width of the entry count
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  // key normalization: stop at the first zero byte, ignore bytes past KEY_BYTES
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             stop;
    logic [7:0]       b;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      b = k[KEY_W-1-8*i -: 8];
      if (i >= KEY_BYTES || b == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[KEY_W-1-8*i -: 8] = b;
      end
    end
    return r;
  endfunction

  state_t           state_r, state_nxt;
  logic             busy_r, busy_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  // search window: lo inclusive, hi exclusive
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  skts_out_t        out_r, out_nxt;

  // ram ports
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [KEY_W-1:0]   probe_key;
  logic [VALUE_W-1:0] probe_value;

  // command decode
  logic             accept;
  logic [KEY_W-1:0] in_key_norm;
  logic             table_full;
  logic [CW-1:0]    first_mid_full;

  // next probe candidates, derived from registers only
  logic [CW:0]      sum_left;
  logic [CW:0]      sum_right;
  logic [CW-1:0]    mid_ext;
  logic [CW-1:0]    mid_plus1;
  logic             key_eq;
  logic             key_lt;
  logic             left_empty;
  logic             right_empty;
  logic [AW+POS_W-1:0] pos_ext;

  assign accept         = start && !busy_r;
  assign in_key_norm    = norm_key(in_data.search_key);
  assign table_full     = (count_r == CW'(TABLE_DEPTH));
  assign first_mid_full = (count_r - CW'(1)) >> 1;

  assign mid_ext     = CW'(mid_r);
  assign mid_plus1   = mid_ext + CW'(1);
  assign sum_left    = {1'b0, lo_r} + {1'b0, mid_ext} - (CW+1)'(1);
  assign sum_right   = {1'b0, mid_ext} + {1'b0, hi_r};
  assign key_eq      = (key_r == probe_key);
  assign key_lt      = (key_r < probe_key);
  assign left_empty  = (mid_ext == lo_r);
  assign right_empty = (mid_plus1 == hi_r);
  assign pos_ext     = {{POS_W{1'b0}}, mid_r};

  assign wr_en = accept && (in_data.operation == OP_APPEND) && !table_full;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = mid_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (!table_full) begin
                count_nxt = count_r + CW'(1);
              end
            end
            OP_LOOKUP: begin
              key_nxt = in_key_norm;
              lo_nxt  = '0;
              hi_nxt  = count_r;
              if (count_r == '0) begin
                // empty table: miss right away
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
              end else begin
                mid_nxt   = first_mid_full[AW-1:0];
                rd_addr   = first_mid_full[AW-1:0];
                busy_nxt  = 1'b1;
                state_nxt = S_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PROBE: begin
        // probed entry at mid_r is on the ram outputs this cycle
        if (key_eq) begin
          out_valid_nxt          = 1'b1;
          out_nxt.found          = 1'b1;
          out_nxt.found_value    = probe_value;
          out_nxt.found_position = pos_ext[POS_W-1:0];
          busy_nxt               = 1'b0;
          state_nxt              = S_IDLE;
        end else if (key_lt) begin
          hi_nxt = mid_ext;
          if (left_empty) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            busy_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            mid_nxt = sum_left[AW:1];
            rd_addr = sum_left[AW:1];
          end
        end else begin
          lo_nxt = mid_plus1;
          if (right_empty) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            busy_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            mid_nxt = sum_right[AW:1];
            rd_addr = sum_right[AW:1];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // search window and result payload
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  // key and value stores, written at the append position, read at the probe
  skts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (in_key_norm),
    .raddr (rd_addr),
    .rdata (probe_key)
  );

  skts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.entry_value),
    .raddr (rd_addr),
    .rdata (probe_value)
  );

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/skts_checker.sv =====
// ---------------------------------------------------------------------------
// skts_checker
// watches the command and result channels of the key table search block,
// keeps its own copy of the table and compares every lookup answer
// ---------------------------------------------------------------------------
module skts_checker
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  skts_in_t  in_data,
  input  logic      out_valid,
  input  skts_out_t out_data,
  output int        pending,
  output int        mismatches
);

  logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
  logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];
  int                 entry_count = 0;
  int                 fail_count  = 0;
  skts_out_t          answer_q [$];

  // bytes past the first zero read as zero, only the top KEY_BYTES count
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] r;
    logic             hit_zero;
    r        = '0;
    hit_zero = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_BYTES || raw[KEY_W-1-8*i -: 8] == 8'h00) hit_zero = 1'b1;
      if (!hit_zero) r[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
    end
    return r;
  endfunction

  // binary search over the entries written so far
  function automatic skts_out_t search_answer(input logic [KEY_W-1:0] key);
    skts_out_t r;
    int        lo;
    int        hi;
    int        mid;
    r  = '0;
    lo = 0;
    hi = entry_count - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (key == key_mem[mid]) begin
        r.found          = 1'b1;
        r.found_value    = value_mem[mid];
        r.found_position = mid[POS_W-1:0];
      end else if (key < key_mem[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    skts_out_t want;
    if (!rst_n) begin
      entry_count = 0;
      answer_q.delete();
    end else begin
      // the answer leaving now belongs to an earlier lookup
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected lookup answer: found=%0d value=%h pos=%0d",
                     out_data.found, out_data.found_value, out_data.found_position);
        end else begin
          want = answer_q.pop_front();
          if (out_data.found !== want.found || out_data.found_value !== want.found_value ||
              out_data.found_position !== want.found_position) begin
            fail_count++;
            if (fail_count <= 10)
              $display("lookup mismatch: exp found=%0d value=%h pos=%0d, got found=%0d value=%h pos=%0d",
                       want.found, want.found_value, want.found_position,
                       out_data.found, out_data.found_value, out_data.found_position);
          end
        end
      end
      if (start && !busy) begin
        case (skts_op_t'(in_data.operation))
          OP_CLEAR: entry_count = 0;
          OP_APPEND: begin
            if (entry_count < TABLE_DEPTH) begin
              key_mem[entry_count]   = norm_key(in_data.search_key);
              value_mem[entry_count] = in_data.entry_value;
              entry_count++;
            end
          end
          OP_LOOKUP: answer_q.push_back(search_answer(norm_key(in_data.search_key)));
          default: ;
        endcase
      end
    end
    pending    <= answer_q.size();
    mismatches <= fail_count;
  end

endmodule

// ===== tb/sorted_key_table_search_test.sv =====
// ---------------------------------------------------------------------------
// sorted_key_table_search_test
// drives clear, append and lookup commands into the key table search block
// in bursts with random gaps; a checker beside the block predicts each
// lookup answer and counts mismatches, and the verdict comes from its count
// ---------------------------------------------------------------------------
module sorted_key_table_search_test;
  import skts_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int ITEM_TARGET  = 800;
  localparam int LADDER_SIZE  = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_SET      = 120;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  skts_in_t  in_data;
  logic      out_valid;
  skts_out_t out_data;

  int pending;
  int mismatches;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent_items  = 0;

  // raw keys appended since the last clear, used to pick lookups that hit
  logic [KEY_W-1:0] loaded_keys [$];
  logic [KEY_W-1:0] sort_buf [MAX_SET];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_key_table_search u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  skts_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .pending   (pending),
    .mismatches(mismatches)
  );

  // hard stop in case a lookup never answers
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random text key: up to eight nonzero characters, then a zero and
  // sometimes garbage after it that the block must ignore
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    int               len;
    k   = '0;
    len = $urandom_range(0, 8);
    for (int i = 0; i < 8; i++) begin
      if (i < len) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
      else if (i > len && $urandom_range(0, 1) == 1)
        k[KEY_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
    end
    return k;
  endfunction

  // same key as far as the block is concerned: scramble bytes past the first zero
  function automatic logic [KEY_W-1:0] with_noise_tail(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             past_zero;
    r         = k;
    past_zero = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (past_zero) r[8*i +: 8] = 8'($urandom_range(0, 255));
      else if (r[8*i +: 8] == 8'h00) past_zero = 1'b1;
    end
    return r;
  endfunction

  // ascending keys for the ladder pass: "key" plus three letters
  function automatic logic [KEY_W-1:0] ladder_key(input logic [11:0] idx);
    return {8'h6B, 8'h65, 8'h79, 8'h41 + {4'h0, idx[11:8]},
            8'h41 + {4'h0, idx[7:4]}, 8'h41 + {4'h0, idx[3:0]}, 16'h0000};
  endfunction

  // one command transfer; start stays high afterward unless a gap follows
  task automatic issue(input skts_op_t op, input logic [KEY_W-1:0] key,
                       input logic [VALUE_W-1:0] value);
    skts_in_t item;
    int       gap;
    item.operation   = op;
    item.search_key  = key;
    item.entry_value = value;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    // mirror the table for picking hits
    if (op == OP_CLEAR) loaded_keys.delete();
    if (op == OP_APPEND && loaded_keys.size() < TABLE_DEPTH) loaded_keys.push_back(key);
    if (op != OP_NONE) sent_items++;
    // bursts of back-to-back commands, then an idle gap of random length
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // sender holds off until every lookup answer has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // lookups that mostly hit loaded keys, the rest random
  task automatic lookups(input int count);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      if (loaded_keys.size() > 0 && $urandom_range(0, 3) != 0)
        k = with_noise_tail(loaded_keys[$urandom_range(0, loaded_keys.size() - 1)]);
      else
        k = rand_key();
      issue(OP_LOOKUP, k, $urandom());
    end
  endtask

  // clear, then append count keys in ascending order
  task automatic load_sorted(input int count);
    logic [KEY_W-1:0] k;
    int               j;
    issue(OP_CLEAR, rand_key(), $urandom());
    for (int i = 0; i < count; i++) begin
      // insertion into the sorted buffer; raw order keeps normalized order
      k = rand_key();
      j = i;
      while (j > 0 && sort_buf[j-1] > k) begin
        sort_buf[j] = sort_buf[j-1];
        j--;
      end
      sort_buf[j] = k;
    end
    for (int i = 0; i < count; i++) issue(OP_APPEND, sort_buf[i], $urandom());
  endtask

  initial begin
    int n;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // lookups on an empty table, and the ignored opcode
    issue(OP_LOOKUP, '0, '0);
    issue(OP_LOOKUP, '1, '1);
    issue(OP_NONE, '1, '1);
    // extremes appended out of order, so the probe walk sees an unsorted table
    issue(OP_APPEND, '1, '1);
    issue(OP_APPEND, '0, '0);
    issue(OP_APPEND, 64'h4100_FFFF_FFFF_FFFF, 32'h5A5A_A5A5);
    issue(OP_LOOKUP, '1, '0);
    issue(OP_LOOKUP, '0, '1);
    issue(OP_LOOKUP, 64'h4100_0000_0000_0000, '0);
    issue(OP_LOOKUP, 64'h4200_0000_0000_0000, '0);
    // clear leaves the stores alone but nothing may be found afterward
    issue(OP_CLEAR, '1, '1);
    issue(OP_LOOKUP, '1, '0);
    issue(OP_LOOKUP, '0, '0);
    drain();

    // a long ascending ladder, then the largest key on top of it
    issue(OP_CLEAR, '0, '0);
    for (int i = 0; i < LADDER_SIZE; i++) issue(OP_APPEND, ladder_key(12'(i)), $urandom());
    issue(OP_APPEND, '1, '1);
    issue(OP_LOOKUP, ladder_key(12'd0), '0);
    issue(OP_LOOKUP, ladder_key(12'(LADDER_SIZE - 1)), '0);
    issue(OP_LOOKUP, with_noise_tail(ladder_key(12'(LADDER_SIZE / 2))), '0);
    issue(OP_LOOKUP, '1, '0);
    issue(OP_LOOKUP, '0, '0);
    issue(OP_LOOKUP, ladder_key(12'd100) + 64'h1, '0);
    for (int i = 0; i < 12; i++)
      issue(OP_LOOKUP,
            with_noise_tail(ladder_key(12'($urandom_range(0, LADDER_SIZE - 1)))), '0);
    drain();

    // random part: mostly clean sorted loads with lookups, some noise
    while (sent_items < ITEM_TARGET) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, MAX_SET) : $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          load_sorted(n);
          lookups($urandom_range(1, 2 * n + 2));
        end
        7: begin
          // unsorted appends, sometimes on top of what is already there
          if ($urandom_range(0, 1) == 0) issue(OP_CLEAR, rand_key(), $urandom());
          for (int i = 0; i < n; i++) issue(OP_APPEND, rand_key(), $urandom());
          lookups($urandom_range(1, n + 2));
        end
        8: begin
          for (int i = 0; i < 8; i++)
            issue(skts_op_t'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) == 0) ? {$urandom(), $urandom()} : rand_key(),
                  $urandom());
        end
        default: begin
          for (int i = 0; i < n; i++) issue(OP_APPEND, rand_key(), $urandom());
          lookups($urandom_range(1, 10));
        end
      endcase
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
